FILE: src/mp3_frame_duration_scanner_top_macros.svh
// Assertion macros for the frame duration scanner checker.
`ifndef MP3_FRAME_DURATION_SCANNER_TOP_MACROS_SVH
`define MP3_FRAME_DURATION_SCANNER_TOP_MACROS_SVH
// Assert that a implies b at the next edge.
`define MFD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mfd check failed");
// Assert that a implies b at the same edge.
`define MFD_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mfd check failed");
`endif

FILE: src/mfd_pkg.sv
package mfd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mfd_in_t;

  typedef struct packed {
    logic [23:0] duration_sec;
    logic [23:0] frames_found;
    logic [1:0]  result_source;
  } mfd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_FDIV,
    ST_DDIV,
    ST_OUT
  } mfd_state_t;

  typedef enum logic [1:0] {
    SRC_SCAN  = 2'd0,
    SRC_FALLB = 2'd1,
    SRC_SHORT = 2'd2
  } mfd_src_t;

  localparam logic [2:0] REG_MIN  = 3'd0;
  localparam logic [2:0] REG_MAX  = 3'd1;
  localparam logic [2:0] REG_DEF  = 3'd2;
  localparam logic [2:0] REG_BPS  = 3'd3;
  localparam logic [2:0] REG_FMIN = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // run the byte through the scan
    logic hdr_apply;   // apply the decoded header
    logic fdiv_start;  // start frame-size division
    logic ddiv_start;  // start final-duration division
    logic finish;      // build the result and clear the file state
  } mfd_cmd_t;

  typedef struct packed {
    logic hdr_hit;     // byte completes a valid-synced header
    logic need_ddiv;   // final result needs a division
    logic div_busy;
  } mfd_sts_t;

  function automatic logic [9:0] kbps_lookup(input logic [2:0] row, input logic [3:0] bri);
    logic [9:0] v;
    v = 10'd0;
    case (row)
      3'd0: case (bri)
        4'd1: v = 10'd32; 4'd2: v = 10'd64; 4'd3: v = 10'd96; 4'd4: v = 10'd128;
        4'd5: v = 10'd160; 4'd6: v = 10'd192; 4'd7: v = 10'd224; 4'd8: v = 10'd256;
        4'd9: v = 10'd288; 4'd10: v = 10'd320; 4'd11: v = 10'd352;
        4'd12: v = 10'd384; 4'd13: v = 10'd416; 4'd14: v = 10'd448; default: v = 10'd0;
      endcase
      3'd1: case (bri)
        4'd1: v = 10'd32; 4'd2: v = 10'd48; 4'd3: v = 10'd56; 4'd4: v = 10'd64;
        4'd5: v = 10'd80; 4'd6: v = 10'd96; 4'd7: v = 10'd112; 4'd8: v = 10'd128;
        4'd9: v = 10'd160; 4'd10: v = 10'd192; 4'd11: v = 10'd224;
        4'd12: v = 10'd256; 4'd13: v = 10'd320; 4'd14: v = 10'd384; default: v = 10'd0;
      endcase
      3'd2: case (bri)
        4'd1: v = 10'd32; 4'd2: v = 10'd40; 4'd3: v = 10'd48; 4'd4: v = 10'd56;
        4'd5: v = 10'd64; 4'd6: v = 10'd80; 4'd7: v = 10'd96; 4'd8: v = 10'd112;
        4'd9: v = 10'd128; 4'd10: v = 10'd160; 4'd11: v = 10'd192;
        4'd12: v = 10'd224; 4'd13: v = 10'd256; 4'd14: v = 10'd320; default: v = 10'd0;
      endcase
      3'd3: case (bri)
        4'd1: v = 10'd32; 4'd2: v = 10'd48; 4'd3: v = 10'd56; 4'd4: v = 10'd64;
        4'd5: v = 10'd80; 4'd6: v = 10'd96; 4'd7: v = 10'd112; 4'd8: v = 10'd128;
        4'd9: v = 10'd144; 4'd10: v = 10'd160; 4'd11: v = 10'd176;
        4'd12: v = 10'd192; 4'd13: v = 10'd224; 4'd14: v = 10'd256; default: v = 10'd0;
      endcase
      default: case (bri)
        4'd1: v = 10'd8; 4'd2: v = 10'd16; 4'd3: v = 10'd24; 4'd4: v = 10'd32;
        4'd5: v = 10'd40; 4'd6: v = 10'd48; 4'd7: v = 10'd56; 4'd8: v = 10'd64;
        4'd9: v = 10'd80; 4'd10: v = 10'd96; 4'd11: v = 10'd112;
        4'd12: v = 10'd128; 4'd13: v = 10'd144; 4'd14: v = 10'd160; default: v = 10'd0;
      endcase
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] v;
    v = 16'd0;
    case ({ver, sri})
      4'b0000: v = 16'd11025;
      4'b0001: v = 16'd12000;
      4'b0010: v = 16'd8000;
      4'b1000: v = 16'd22050;
      4'b1001: v = 16'd24000;
      4'b1010: v = 16'd16000;
      4'b1100: v = 16'd44100;
      4'b1101: v = 16'd48000;
      4'b1110: v = 16'd32000;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/mfd_div.sv
// Restoring divider, one quotient bit per cycle.
module mfd_div import mfd_pkg::*; #(
  parameter int NW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [15:0]   den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [15:0]   den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [16:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[15:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quo = q_r;
endmodule

FILE: src/mfd_datapath.sv
module mfd_datapath import mfd_pkg::*; #(
  parameter int SIZE_BITS = 32,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mfd_in_t     in_item,
  input  mfd_cmd_t    cmd,
  output mfd_sts_t    sts,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output mfd_out_t    result
);
  localparam int NW = (SIZE_BITS > 36) ? SIZE_BITS : 36;
  localparam logic [SIZE_BITS-1:0] PMAX = '1;
  localparam logic [FRAME_COUNT_BITS-1:0] FMAX = '1;
  localparam logic [35:0] SMAX = '1;

  logic [15:0] min_r, max_r, def_r, bps_r;
  logic [7:0]  fmin_r;

  logic [SIZE_BITS-1:0] pos_r;
  logic [31:0] skip_r;
  logic [23:0] win_r;
  logic [1:0]  fill_r;
  logic [27:0] tag_r;
  logic [35:0] samp_r;
  logic [FRAME_COUNT_BITS-1:0] frm_r;
  logic [15:0] fsr_r;
  logic        stop_r, phase_r, id3_r;
  // latched header fields
  logic [1:0]  lay_r;
  logic        pad_r;
  logic [15:0] sr_r;
  logic [27:0] fnum_r;

  logic [SIZE_BITS-1:0] pos_inc;
  logic [7:0] h0, h1, h2;
  logic [1:0] ver, lay, sri;
  logic [3:0] bri;
  logic [2:0] row;
  logic [9:0] kbps;
  logic [15:0] sr;
  logic sync, valid_hdr, scan_act;
  logic [27:0] tag_nxt;
  logic        tag_drop;
  logic [36:0] samp_sum;

  logic          dv_start, dv_busy;
  logic [NW-1:0] dv_num, dv_quo;
  logic [15:0]   dv_den;

  assign pos_inc = (pos_r != PMAX) ? pos_r + 1'b1 : pos_r;
  assign h0 = win_r[23:16];
  assign h1 = win_r[15:8];
  assign h2 = win_r[7:0];
  assign ver = h1[4:3];
  assign lay = h1[2:1];
  assign bri = h2[7:4];
  assign sri = h2[3:2];
  assign sync = (h0 == 8'hFF) && ((h1 & 8'hE0) == 8'hE0);
  assign row = (ver == 2'd3) ? ((lay == 2'd3) ? 3'd0 : (lay == 2'd2) ? 3'd1 : 3'd2)
                             : ((lay == 2'd3) ? 3'd3 : 3'd4);
  assign kbps = kbps_lookup(row, bri);
  assign sr = rate_lookup(ver, sri);
  assign valid_hdr = (ver != 2'd1) && (lay != 2'd0) && (bri != 4'd0) && (bri != 4'd15)
                     && (sri != 2'd3) && (kbps != 0) && (sr != 0);
  assign scan_act = !stop_r && (skip_r == 0) && (fill_r == 2'd3);
  // an ID3 tag ending on this byte drops the whole scan, header included
  assign tag_nxt = {tag_r[20:0], in_item.data_byte[6:0]};
  assign tag_drop = !phase_r && (pos_inc >= SIZE_BITS'(10)) && id3_r;
  assign sts.hdr_hit = scan_act && sync && valid_hdr && !tag_drop;
  assign sts.div_busy = dv_busy;
  assign samp_sum = {1'b0, samp_r} + ((lay == 2'd3) ? 37'd384 :
                    (lay == 2'd2 || ver == 2'd3) ? 37'd1152 : 37'd576);

  // numerator of frame size: 12000*kbps for layer I, else 144000 or 72000
  logic [27:0] fnum;
  always_comb begin
    if (lay == 2'd3) fnum = 28'(kbps) * 28'd12000;
    else if (lay == 2'd2 || ver == 2'd3) fnum = 28'(kbps) * 28'd144000;
    else fnum = 28'(kbps) * 28'd72000;
  end

  // final decision
  logic short_f, scan_res;
  assign short_f = (pos_r < SIZE_BITS'(10));
  assign scan_res = (frm_r != 0) && (fsr_r != 0);
  assign sts.need_ddiv = !short_f;

  always_comb begin
    dv_start = cmd.fdiv_start || cmd.ddiv_start;
    dv_num = NW'(fnum_r);
    dv_den = sr_r;
    if (cmd.ddiv_start) begin
      if (scan_res) begin
        dv_num = NW'(samp_r);
        dv_den = fsr_r;
      end else begin
        dv_num = NW'(pos_r);
        dv_den = (bps_r == 0) ? 16'd1 : bps_r;
      end
    end
  end

  mfd_div #(.NW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_quo)
  );

  // frame size from quotient
  logic [31:0] fs;
  logic [NW:0] dur;
  always_comb begin
    if (lay_r == 2'd3) fs = (32'(dv_quo[27:0]) + 32'(pad_r)) << 2;
    else fs = 32'(dv_quo[27:0]) + 32'(pad_r);
    dur = {1'b0, dv_quo};
    if (scan_res) begin
      if (dur < (NW+1)'(min_r)) dur = (NW+1)'(min_r);
      if (dur > (NW+1)'(max_r)) dur = (NW+1)'(max_r);
    end else if (dur < (NW+1)'(fmin_r)) begin
      dur = (NW+1)'(def_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 16'd5; max_r <= 16'd7200; def_r <= 16'd240;
      bps_r <= 16'd16000; fmin_r <= 8'd10;
      pos_r <= '0; skip_r <= '0; win_r <= '0; fill_r <= '0; tag_r <= '0;
      samp_r <= '0; frm_r <= '0; fsr_r <= '0; stop_r <= 1'b0;
      phase_r <= 1'b0; id3_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN:  min_r <= cfg_data;
          REG_MAX:  max_r <= cfg_data;
          REG_DEF:  def_r <= cfg_data;
          REG_BPS:  bps_r <= cfg_data;
          REG_FMIN: fmin_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.take_byte) begin
        pos_r <= pos_inc;
        if (tag_drop) begin
          phase_r <= 1'b1;
          skip_r <= 32'(tag_nxt); win_r <= '0; fill_r <= '0; samp_r <= '0;
          frm_r <= '0; fsr_r <= '0; stop_r <= 1'b0;
        end else begin
          if (!stop_r) begin
            if (skip_r != 0) skip_r <= skip_r - 1'b1;
            else if (fill_r != 2'd3) begin
              win_r <= {win_r[15:0], in_item.data_byte};
              fill_r <= fill_r + 1'b1;
            end else if (!sync) begin
              win_r <= {win_r[15:0], in_item.data_byte};
            end else begin
              win_r <= '0;
              fill_r <= '0;
              if (valid_hdr) begin
                lay_r <= lay; pad_r <= h2[1];
                sr_r <= sr; fnum_r <= fnum;
                if (fsr_r == 0) fsr_r <= sr;
                samp_r <= samp_sum[36] ? SMAX : samp_sum[35:0];
                if (frm_r != FMAX) frm_r <= frm_r + 1'b1;
              end
            end
          end
          // tag phase uses the new byte position
          if (!phase_r) begin
            if (pos_inc == SIZE_BITS'(1) && in_item.data_byte != 8'h49) id3_r <= 1'b0;
            if (pos_inc == SIZE_BITS'(2) && in_item.data_byte != 8'h44) id3_r <= 1'b0;
            if (pos_inc == SIZE_BITS'(3) && in_item.data_byte != 8'h33) id3_r <= 1'b0;
            if (pos_inc >= SIZE_BITS'(7)) tag_r <= tag_nxt;
            if (pos_inc >= SIZE_BITS'(10)) phase_r <= 1'b1;
          end
        end
      end
      if (cmd.hdr_apply) begin
        // runs after frame-size division
        if (fs < 32'd4) stop_r <= 1'b1;
        else skip_r <= fs - 32'd4;
      end
      if (cmd.finish) begin
        pos_r <= '0; skip_r <= '0; win_r <= '0; fill_r <= '0; tag_r <= '0;
        samp_r <= '0; frm_r <= '0; fsr_r <= '0; stop_r <= 1'b0;
        phase_r <= 1'b0; id3_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (short_f) begin
        result.duration_sec <= 24'(def_r);
        result.frames_found <= '0;
        result.result_source <= SRC_SHORT;
      end else begin
        result.duration_sec <= (dur > (NW+1)'(24'hFFFFFF)) ? 24'hFFFFFF : dur[23:0];
        result.frames_found <= scan_res ?
          ((32'(frm_r) > 32'hFFFFFF) ? 24'hFFFFFF : 24'(frm_r)) : 24'd0;
        result.result_source <= scan_res ? SRC_SCAN : SRC_FALLB;
      end
    end
  end
endmodule

FILE: src/mfd_ctrl.sv
module mfd_ctrl import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  mfd_in_t  in_item,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output mfd_cmd_t cmd,
  input  mfd_sts_t sts
);
  mfd_state_t state_r, state_nxt;
  logic last_r, last_nxt;
  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    last_nxt = last_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          cmd.take_byte = 1'b1;
          last_nxt = in_item.last_byte;
          if (sts.hdr_hit) begin
            state_nxt = ST_HDR;
          end else if (in_item.last_byte) begin
            state_nxt = ST_FDIV;
          end
        end
      end
      ST_HDR: begin
        cmd.fdiv_start = 1'b1;
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        if (!sts.div_busy) begin
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            if (sts.need_ddiv) cmd.ddiv_start = 1'b1;
            state_nxt = ST_DDIV;
          end
        end
      end
      ST_DDIV: begin
        if (!sts.div_busy) begin
          cmd.finish = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r <= last_nxt;
    end
  end
endmodule

FILE: src/mp3_frame_duration_scanner_top.sv
// MPEG audio duration scanner.
// Input channel: one file byte per transfer (in_valid / in_stall), with
// last_byte set on the final byte of a file. Output channel: one result
// per file, presented with out_valid until a cycle with out_stall low.
// Configuration: cfg_wr_en / cfg_index / cfg_data, written while idle.
// Input holds: an ordinary byte never holds the input. A byte completing
// a valid header holds it while the frame-size division starts and runs
// on the shared serial divider (one quotient bit per cycle) and the frame
// skip is loaded; the frame skip then runs at the byte rate. Latency: the
// controller starts the final-duration division in ST_FDIV after the
// final byte (not for a file under ten bytes), waits in ST_DDIV and
// offers the result in ST_OUT; a final byte that completes a header first
// passes ST_HDR and the frame-size division. The result then waits on the
// output until taken; the next byte is taken the cycle after.
// Reset: all scan state clears and the registers return to their
// defaults. A stalled result holds its value and blocks new bytes.
module mp3_frame_duration_scanner_top import mfd_pkg::*; #(
  parameter int SIZE_BITS = 32,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mfd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output mfd_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  mfd_cmd_t cmd;
  mfd_sts_t sts;
  mfd_cmd_t dcmd;

  mfd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_item(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  // apply the header once its frame-size quotient is ready
  logic hdr_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) hdr_pend_r <= 1'b0;
    else if (cmd.fdiv_start) hdr_pend_r <= 1'b1;
    else if (hdr_pend_r && !sts.div_busy) hdr_pend_r <= 1'b0;
  end
  always_comb begin
    dcmd = cmd;
    dcmd.hdr_apply = hdr_pend_r && !sts.div_busy;
  end

  mfd_datapath #(.SIZE_BITS(SIZE_BITS), .FRAME_COUNT_BITS(FRAME_COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(dcmd), .sts(sts),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result(out_data)
  );
endmodule

FILE: src/mfd_checker.sv
`include "mp3_frame_duration_scanner_top_macros.svh"
module mfd_checker import mfd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input mfd_out_t out_data
);
  `MFD_ASSERT_NOW(a_no_in_while_out, out_valid, in_stall)
  `MFD_ASSERT_NOW(a_src_code, out_valid, out_data.result_source != 2'd3)
  `MFD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

bind mp3_frame_duration_scanner_top mfd_checker u_mfd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

FILE: tb/tb_mp3_frame_duration_scanner_top.sv
`timescale 1ns / 1ps

module tb_mp3_frame_duration_scanner_top import mfd_pkg::*;;

  localparam logic [31:0] BYTE_POS_MAX = 32'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  mfd_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  mfd_out_t    out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  mp3_frame_duration_scanner_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the registers.
  logic [15:0] min_dur, max_dur, def_dur, bytes_per_sec;
  logic [7:0]  fb_min;

  // Shadow scan state for the file in flight.
  logic        in_tag_phase;
  logic [31:0] byte_pos;
  logic [31:0] frame_skip;
  logic [23:0] hdr_win;
  logic [1:0]  win_fill;
  logic [27:0] tag_len;
  logic [35:0] sample_total;
  logic [23:0] frame_cnt;
  logic [15:0] first_rate;
  logic        scan_halted;
  logic        id3_seen;

  mfd_in_t  byte_queue[$];
  mfd_out_t duration_queue[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       gaps_on;
  bit       hold_off_req;

  task automatic clear_file_scan();
    frame_skip = 0; hdr_win = 0; win_fill = 0;
    sample_total = 0; frame_cnt = 0; first_rate = 0; scan_halted = 1'b0;
  endtask

  task automatic clear_file();
    clear_file_scan();
    in_tag_phase = 1'b1; byte_pos = 0; tag_len = 0; id3_seen = 1'b1;
  endtask

  function automatic int unsigned bitrate_kbps(int unsigned row, int unsigned idx);
    int unsigned r0[16] = '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0};
    int unsigned r1[16] = '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0};
    int unsigned r2[16] = '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0};
    int unsigned r3[16] = '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0};
    int unsigned r4[16] = '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0};
    case (row)
      0: return r0[idx];
      1: return r1[idx];
      2: return r2[idx];
      3: return r3[idx];
      default: return r4[idx];
    endcase
  endfunction

  function automatic int unsigned rate_hz(int unsigned ver, int unsigned sri);
    int unsigned base;
    if (sri == 3 || ver == 1) return 0;
    base = (ver == 3) ? 44100 : (ver == 2) ? 22050 : 11025;
    if (sri == 1) return (ver == 3) ? 48000 : (ver == 2) ? 24000 : 12000;
    if (sri == 2) return (ver == 3) ? 32000 : (ver == 2) ? 16000 : 8000;
    return base;
  endfunction

  // Advance the frame hunt by one byte.
  task automatic hunt_byte(logic [7:0] b);
    int unsigned ver, lay, bri, sri, pad, kbps, sr, spf, fs, row;
    if (scan_halted) return;
    if (frame_skip != 0) begin
      frame_skip--;
      return;
    end
    if (win_fill < 3) begin
      hdr_win = {hdr_win[15:0], b};
      win_fill++;
      return;
    end
    if (hdr_win[23:16] != 8'hFF || hdr_win[15:13] != 3'b111) begin
      hdr_win = {hdr_win[15:0], b};
      return;
    end
    ver = hdr_win[12:11]; lay = hdr_win[10:9];
    bri = hdr_win[7:4]; sri = hdr_win[3:2]; pad = hdr_win[1];
    hdr_win = 0;
    win_fill = 0;
    if (ver == 1 || lay == 0 || bri == 0 || bri == 15 || sri == 3) return;
    if (ver == 3) row = (lay == 3) ? 0 : (lay == 2) ? 1 : 2;
    else row = (lay == 3) ? 3 : 4;
    kbps = bitrate_kbps(row, bri);
    sr = rate_hz(ver, sri);
    if (kbps == 0 || sr == 0) return;
    if (first_rate == 0) first_rate = sr;
    spf = (lay == 3) ? 384 : (lay == 2 || ver == 3) ? 1152 : 576;
    if (sample_total > 36'hF_FFFF_FFFF - spf) sample_total = 36'hF_FFFF_FFFF;
    else sample_total += spf;
    if (frame_cnt != 24'hFF_FFFF) frame_cnt++;
    if (lay == 3) fs = (12 * kbps * 1000 / sr + pad) * 4;
    else if (lay == 2 || ver == 3) fs = 144 * kbps * 1000 / sr + pad;
    else fs = 72 * kbps * 1000 / sr + pad;
    if (fs < 4) scan_halted = 1'b1;
    else frame_skip = fs - 4;
  endtask

  // Predict the result of one byte transfer; push it when the file ends.
  task automatic predict_duration(mfd_in_t it);
    logic [63:0] dur;
    logic [63:0] frames;
    logic [15:0] div;
    mfd_out_t    res;
    frames = 0;
    if (byte_pos != BYTE_POS_MAX) byte_pos++;
    hunt_byte(it.data_byte);
    if (in_tag_phase) begin
      if (byte_pos == 1 && it.data_byte != 8'h49) id3_seen = 1'b0;
      if (byte_pos == 2 && it.data_byte != 8'h44) id3_seen = 1'b0;
      if (byte_pos == 3 && it.data_byte != 8'h33) id3_seen = 1'b0;
      if (byte_pos >= 7) tag_len = {tag_len[20:0], it.data_byte[6:0]};
      if (byte_pos >= 10) begin
        in_tag_phase = 1'b0;
        if (id3_seen) begin
          clear_file_scan();
          frame_skip = tag_len;
        end
      end
    end
    if (!it.last_byte) return;
    if (byte_pos < 10) begin
      dur = def_dur;
      res.result_source = SRC_SHORT;
    end else if (frame_cnt != 0 && first_rate != 0) begin
      dur = sample_total / first_rate;
      if (dur < min_dur) dur = min_dur;
      if (dur > max_dur) dur = max_dur;
      frames = frame_cnt;
      res.result_source = SRC_SCAN;
    end else begin
      div = (bytes_per_sec == 0) ? 16'd1 : bytes_per_sec;
      dur = byte_pos / div;
      if (dur < fb_min) dur = def_dur;
      res.result_source = SRC_FALLB;
    end
    res.duration_sec = (dur > 64'hFF_FFFF) ? 24'hFF_FFFF : dur[23:0];
    res.frames_found = (frames > 64'hFF_FFFF) ? 24'hFF_FFFF : frames[23:0];
    duration_queue.push_back(res);
    clear_file();
  endtask

  // Driver: offer queued bytes, with random idle bursts.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_duration(in_data);
        void'(byte_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= byte_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random, compare each accepted result.
  int out_gap;
  int hold_off_left;
  bit hold_off_done;
  always @(posedge clk) begin
    mfd_out_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
      hold_off_left = 0;
      hold_off_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (duration_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          exp_res = duration_queue.pop_front();
          if (out_data.duration_sec !== exp_res.duration_sec)
            $display("%0t: duration_sec expected %0d actual %0d", $time,
                     exp_res.duration_sec, out_data.duration_sec);
          if (out_data.frames_found !== exp_res.frames_found)
            $display("%0t: frames_found expected %0d actual %0d", $time,
                     exp_res.frames_found, out_data.frames_found);
          if (out_data.result_source !== exp_res.result_source)
            $display("%0t: result_source expected %0d actual %0d", $time,
                     exp_res.result_source, out_data.result_source);
          if (out_data !== exp_res) fail_count++;
        end
      end
      if (hold_off_req && !hold_off_done) begin
        hold_off_left = 3000;
        hold_off_done = 1'b1;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mp3_frame_duration_scanner_top test failed");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    mfd_in_t it;
    it.data_byte = b;
    it.last_byte = last;
    byte_queue.push_back(it);
  endtask

  // Write a register while the block is idle and mirror it.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MIN:  min_dur = val;
      REG_MAX:  max_dur = val;
      REG_DEF:  def_dur = val;
      REG_BPS:  bytes_per_sec = val;
      REG_FMIN: fb_min = val[7:0];
      default: ;
    endcase
  endtask

  // Wait until all queued bytes went in and all results came out.
  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_valid || duration_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Push a frame header with the given fields (other bits random), then its body as random bytes.
  task automatic push_header(logic [1:0] ver, logic [1:0] lay, logic [3:0] bri,
                             logic [1:0] sri, int body);
    push_byte(8'hFF, 1'b0);
    push_byte({3'b111, ver, lay, 1'($urandom)}, 1'b0);
    push_byte({bri, sri, 2'($urandom)}, 1'b0);
    push_byte(8'($urandom), 1'b0);
    repeat (body) push_byte(8'($urandom), 1'b0);
  endtask

  // Random file: mostly headers with plausible fields, some noise.
  task automatic push_file(int frames);
    int k;
    int n;
    if ($urandom_range(0, 3) == 0) begin
      push_byte(8'h49, 1'b0); push_byte(8'h44, 1'b0); push_byte(8'h33, 1'b0);
      repeat (3) push_byte(8'($urandom), 1'b0);
      n = $urandom_range(0, 12);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'(n), 1'b0);
      repeat (n) push_byte(8'($urandom), 1'b0);
    end
    for (k = 0; k < frames; k++) begin
      case ($urandom_range(0, 5))
        0: push_byte(8'($urandom), 1'b0);
        1: push_header(2'($urandom), 2'($urandom), 4'($urandom), 2'($urandom),
                       $urandom_range(0, 4));
        default: push_header($urandom_range(0, 1) ? 2'd3 : 2'($urandom_range(0, 2) & 2'b10),
                             2'($urandom_range(1, 3)), 4'($urandom_range(1, 14)),
                             2'($urandom_range(0, 2)), $urandom_range(0, 6));
      endcase
    end
    push_byte(8'($urandom), 1'b1);
  endtask

  int total;
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MIN;
    cfg_data = '0;
    gaps_on = 1'b1;
    hold_off_req = 1'b0;
    min_dur = 16'd5; max_dur = 16'd7200; def_dur = 16'd240;
    bytes_per_sec = 16'd16000; fb_min = 8'd10;
    clear_file();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: too-short file, single-byte file, all-ones bytes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    // Free-format-free MPEG1 L3 frame at end of file, header finishing on last byte.
    repeat (6) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFB, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h00, 1'b1);
    // ID3 tag of length 2 ending on the last byte (fallback path).
    push_byte(8'h49, 1'b0); push_byte(8'h44, 1'b0); push_byte(8'h33, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h02, 1'b1);
    wait_idle();

    // Extreme clamps: min above max, zero divisor, maximal fallback minimum.
    write_reg(REG_MIN, 16'hFFFF);
    write_reg(REG_MAX, 16'h0000);
    write_reg(REG_DEF, 16'hFFFF);
    write_reg(REG_BPS, 16'h0000);
    write_reg(REG_FMIN, 16'h00FF);
    write_reg(3'd7, 16'h1234);
    for (total = 0; total < 3; total++) push_file($urandom_range(0, 6));
    wait_idle();

    write_reg(REG_MIN, 16'd0);
    write_reg(REG_MAX, 16'hFFFF);
    write_reg(REG_DEF, 16'd0);
    write_reg(REG_BPS, 16'd1);
    write_reg(REG_FMIN, 16'd0);
    // Long receiver hold-off while bytes keep coming.
    hold_off_req = 1'b1;
    for (total = 0; total < 7; total++) push_file($urandom_range(1, 8));
    wait_idle();

    write_reg(REG_MIN, 16'($urandom_range(0, 3)));
    write_reg(REG_MAX, 16'($urandom));
    write_reg(REG_DEF, 16'($urandom));
    write_reg(REG_BPS, 16'($urandom_range(1, 40)));
    write_reg(REG_FMIN, 16'($urandom_range(0, 255)));
    total = 0;
    while (total < 7) begin
      push_file($urandom_range(0, 10));
      total++;
    end
    wait_idle();

    // Last stretch without idling.
    gaps_on = 1'b0;
    for (total = 0; total < 6; total++) push_file($urandom_range(0, 10));
    wait_idle();

    if (fail_count == 0) begin
      $display("mp3_frame_duration_scanner_top test passed");
    end else begin
      $display("mp3_frame_duration_scanner_top test failed");
    end
    $finish;
  end

endmodule
